// ===== rtl/vfr_pkg.sv =====
package vfr_pkg;

  // Frame geometry: eleven bytes, checksum in byte 9, tail in byte 10.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 4;

  localparam logic [COUNT_W-1:0] FRAME_LEN = 4'd11;
  localparam logic [COUNT_W-1:0] CHECK_POS = 4'd9;
  localparam logic [COUNT_W-1:0] TAIL_POS  = 4'd10;
  localparam int unsigned        CHECK_IDX = 9;

  // Byte positions of the payload fields within a frame.
  localparam int unsigned POS_FLAG   = 1;
  localparam int unsigned POS_STATUS = 2;
  localparam int unsigned POS_VX_HI  = 3;
  localparam int unsigned POS_VX_LO  = 4;
  localparam int unsigned POS_VY_HI  = 5;
  localparam int unsigned POS_VY_LO  = 6;
  localparam int unsigned POS_WZ_HI  = 7;
  localparam int unsigned POS_WZ_LO  = 8;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_IDX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_IDX   = 1'd1;
  localparam logic [BYTE_W-1:0]    HEADER_RESET   = 8'h7B;
  localparam logic [BYTE_W-1:0]    TAIL_RESET     = 8'h7D;

  // One decoded frame.
  typedef struct packed {
    logic        [BYTE_W-1:0] flag_byte;
    logic        [BYTE_W-1:0] status_byte;
    logic signed [WORD_W-1:0] speed_x;
    logic signed [WORD_W-1:0] speed_y;
    logic signed [WORD_W-1:0] turn_rate;
  } vfr_result_t;

endpackage

// ===== rtl/vfr_if.sv =====
// Byte request channel into the receiver.
interface vfr_in_if
  import vfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame request channel out of the receiver.
interface vfr_out_if
  import vfr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic        [BYTE_W-1:0] flag_byte;
  logic        [BYTE_W-1:0] status_byte;
  logic signed [WORD_W-1:0] speed_x;
  logic signed [WORD_W-1:0] speed_y;
  logic signed [WORD_W-1:0] turn_rate;

  modport source (output valid, output flag_byte, output status_byte, output speed_x,
                  output speed_y, output turn_rate, input ready);
  modport sink   (input valid, input flag_byte, input status_byte, input speed_x,
                  input speed_y, input turn_rate, output ready);
endinterface

// ===== rtl/vfr_parse.sv =====
module vfr_parse
  import vfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] header_byte,
  input  logic [BYTE_W-1:0] tail_byte,
  output logic              res_valid,
  output vfr_result_t       res
);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [BYTE_W-1:0]  xor_r;
  logic [BYTE_W-1:0]  xor_nxt;
  logic [BYTE_W-1:0]  frame_r [CHECK_IDX:1];
  logic [COUNT_W-1:0] pos;

  // A count outside the frame is treated as the start of a new one.
  assign pos = (count_r >= FRAME_LEN) ? '0 : count_r;

  // Byte counter and running checksum.
  always_comb begin
    count_nxt = count_r;
    xor_nxt   = xor_r;
    if (byte_accept) begin
      if (pos == '0) begin
        if (rx_byte == header_byte) begin
          count_nxt = 4'd1;
          xor_nxt   = rx_byte;
        end else begin
          count_nxt = '0;
        end
      end else if (pos == TAIL_POS) begin
        count_nxt = '0;
      end else begin
        count_nxt = pos + 4'd1;
        if (pos < CHECK_POS) begin
          xor_nxt = xor_r ^ rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
    end else begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // Frame bytes 1 to 9 are kept; the header and tail are only compared.
  always_ff @(posedge clk) begin
    for (int i = 1; i <= CHECK_IDX; i++) begin
      if (byte_accept && pos == COUNT_W'(i)) begin
        frame_r[i] <= rx_byte;
      end
    end
  end

  // The tail byte completes the frame; it passes if tail and checksum agree.
  assign res_valid = byte_accept && (pos == TAIL_POS) && (rx_byte == tail_byte) &&
                     (xor_r == frame_r[CHECK_IDX]);

  assign res.flag_byte   = frame_r[POS_FLAG];
  assign res.status_byte = frame_r[POS_STATUS];
  assign res.speed_x     = {frame_r[POS_VX_HI], frame_r[POS_VX_LO]};
  assign res.speed_y     = {frame_r[POS_VY_HI], frame_r[POS_VY_LO]};
  assign res.turn_rate   = {frame_r[POS_WZ_HI], frame_r[POS_WZ_LO]};

endmodule

// ===== rtl/vfr_out_reg.sv =====
module vfr_out_reg
  import vfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  vfr_result_t  res,
  output logic         space,
  vfr_out_if.source    out_ch
);

  logic        valid_r;
  logic        valid_nxt;
  vfr_result_t data_r;

  // The register can take a new result when empty or being drained.
  assign space = !valid_r || out_ch.ready;

  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  // Drive the result channel from the register.
  assign out_ch.valid       = valid_r;
  assign out_ch.flag_byte   = data_r.flag_byte;
  assign out_ch.status_byte = data_r.status_byte;
  assign out_ch.speed_x     = data_r.speed_x;
  assign out_ch.speed_y     = data_r.speed_y;
  assign out_ch.turn_rate   = data_r.turn_rate;

endmodule

// ===== rtl/velocity_frame_receiver_top.sv =====
// A result request is valid in the cycle after its tail byte is accepted.
// Throughput: one byte per cycle; ready drops only while a result waits and the
// result channel is stalled, set by the single output register.
// Reset (synchronous, rst_n low): byte count, checksum and output valid clear,
// header and tail registers return to 0x7B and 0x7D; frame bytes are not reset.
module velocity_frame_receiver_top
  import vfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  vfr_in_if.sink               in_ch,
  vfr_out_if.source            out_ch
);

  logic [BYTE_W-1:0] header_r;
  logic [BYTE_W-1:0] tail_r;
  logic              space;
  logic              byte_accept;
  logic              res_valid;
  vfr_result_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      tail_r   <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_IDX: header_r <= cfg_wdata;
        CFG_TAIL_IDX:   tail_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // A byte is taken whenever the output register has room for its result.
  assign in_ch.ready = space;
  assign byte_accept = in_ch.valid && space;

  vfr_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .rx_byte     (in_ch.rx_byte),
    .header_byte (header_r),
    .tail_byte   (tail_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  vfr_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule
